FILE: sv/jcn_pkg.sv
// Shared types, constants and helpers for the joystick calibrate/normalize block.
package jcn_pkg;

  // Converter resolution and derived widths
  localparam int ADC_BITS  = 12;
  localparam int SCALE     = 1000;
  localparam int SCALE_W   = 10;
  localparam int DIFF_W    = ADC_BITS + 1;
  localparam int NUM_W     = ADC_BITS + SCALE_W;
  localparam int OUT_W     = 23;
  localparam int EXT_W     = ((NUM_W + 1 > OUT_W) ? NUM_W + 1 : OUT_W) + 1;
  localparam int STEP_W    = $clog2(NUM_W);

  // Stream payload widths, padded to whole bytes
  localparam int IN_W       = ((2 * ADC_BITS + 2 + 7) / 8) * 8;
  localparam int OUT_USED_W = 2 * OUT_W + 8;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = ADC_BITS;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [SCALE_W-1:0] SCALE_K = SCALE_W'(SCALE);

  localparam logic signed [EXT_W-1:0] OUT_MAX_E = EXT_W'((2 ** (OUT_W - 1)) - 1);
  localparam logic signed [EXT_W-1:0] OUT_MIN_E = EXT_W'(-(2 ** (OUT_W - 1)));

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAL_FIRST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_X     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Y     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y     = 3'd6;

  typedef logic [ADC_BITS-1:0] sample_t;

  // Calibration phases
  typedef enum logic [2:0] {
    PH_SEED,
    PH_WAIT1,
    PH_TRACK,
    PH_WAIT2,
    PH_CENTER,
    PH_WAIT3,
    PH_RUN
  } phase_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    B_IDLE,
    B_DIFF,
    B_SCALE,
    B_DIV,
    B_DONE
  } back_state_t;

  typedef struct packed {
    sample_t mn;
    sample_t ce;
    sample_t mx;
  } axis_cal_t;

  localparam axis_cal_t CAL_RESET = '{mn: ADC_BITS'(0), ce: ADC_BITS'(512),
                                      mx: ADC_BITS'(1024)};

  // One classified sample handed from front to back
  typedef struct packed {
    sample_t   raw_x;
    sample_t   raw_y;
    axis_cal_t cal_x;
    axis_cal_t cal_y;
    logic      pressed_a;
    logic      pressed_b;
    phase_t    phase;
  } job_t;

  // Walk forward through every phase end that this sample satisfies
  function automatic phase_t advance(phase_t start, logic a, logic b);
    phase_t p;
    p = start;
    for (int i = 0; i < 5; i++) begin
      case (p)
        PH_WAIT1:  if (a) p = PH_TRACK;
        PH_TRACK:  if (b) p = PH_WAIT2;
        PH_WAIT2:  if (a) p = PH_CENTER;
        PH_CENTER: if (b) p = PH_WAIT3;
        PH_WAIT3:  if (a) p = PH_RUN;
        default:   ;
      endcase
    end
    return p;
  endfunction

endpackage

FILE: sv/jcn_front.sv
// Front end: config registers, calibration phase sequencing and job issue.
module jcn_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [jcn_pkg::IN_W-1:0]       s_tdata,
  input  logic                           cfg_we,
  input  logic [jcn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jcn_pkg::CFG_W-1:0]      cfg_data,
  output logic                           push,
  output jcn_pkg::job_t                  push_job,
  input  logic                           q_full
);
  import jcn_pkg::*;

  logic      calibrate_first;
  axis_cal_t loaded_x, loaded_y, loaded_x_next, loaded_y_next;
  axis_cal_t cal_x, cal_y, cal_x_next, cal_y_next;
  phase_t    phase, phase_next;
  sample_t   raw_x, raw_y;
  logic      pa, pb;
  logic      loaded_hit;

  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready;

  // Unpack the request and decide the per-sample state update
  always_comb begin
    raw_x      = s_tdata[ADC_BITS-1:0];
    raw_y      = s_tdata[2*ADC_BITS-1:ADC_BITS];
    pa         = ~s_tdata[2*ADC_BITS];
    pb         = ~s_tdata[2*ADC_BITS+1];
    cal_x_next = cal_x;
    cal_y_next = cal_y;
    phase_next = phase;
    unique case (phase)
      PH_SEED: begin
        cal_x_next.mn = raw_x;
        cal_x_next.mx = raw_x;
        cal_y_next.mn = raw_y;
        cal_y_next.mx = raw_y;
        phase_next    = advance(PH_WAIT1, pa, pb);
      end
      PH_TRACK: begin
        if (raw_x > cal_x.mx) cal_x_next.mx = raw_x;
        if (raw_y > cal_y.mx) cal_y_next.mx = raw_y;
        if (raw_x < cal_x.mn) cal_x_next.mn = raw_x;
        if (raw_y < cal_y.mn) cal_y_next.mn = raw_y;
        phase_next = advance(phase, pa, pb);
      end
      PH_CENTER: begin
        cal_x_next.ce = raw_x;
        cal_y_next.ce = raw_y;
        phase_next    = advance(phase, pa, pb);
      end
      PH_RUN: ;
      default: phase_next = advance(phase, pa, pb);
    endcase
  end

  // Job carries the calibration as it stood before this sample
  always_comb begin
    push_job.raw_x     = raw_x;
    push_job.raw_y     = raw_y;
    push_job.cal_x     = cal_x;
    push_job.cal_y     = cal_y;
    push_job.pressed_a = pa;
    push_job.pressed_b = pb;
    push_job.phase     = phase;
  end

  // Config write decode
  always_comb begin
    loaded_x_next = loaded_x;
    loaded_y_next = loaded_y;
    loaded_hit    = 1'b1;
    unique case (cfg_index)
      REG_MIN_X:    loaded_x_next.mn = cfg_data;
      REG_CENTER_X: loaded_x_next.ce = cfg_data;
      REG_MAX_X:    loaded_x_next.mx = cfg_data;
      REG_MIN_Y:    loaded_y_next.mn = cfg_data;
      REG_CENTER_Y: loaded_y_next.ce = cfg_data;
      REG_MAX_Y:    loaded_y_next.mx = cfg_data;
      default:      loaded_hit = 1'b0;
    endcase
  end

  // Phase and calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      calibrate_first <= 1'b1;
      loaded_x        <= CAL_RESET;
      loaded_y        <= CAL_RESET;
      cal_x           <= CAL_RESET;
      cal_y           <= CAL_RESET;
      phase           <= PH_SEED;
    end else if (cfg_we) begin
      loaded_x <= loaded_x_next;
      loaded_y <= loaded_y_next;
      if (cfg_index == REG_CAL_FIRST) begin
        calibrate_first <= cfg_data[0];
        if (cfg_data[0]) begin
          phase <= PH_SEED;
        end else begin
          phase <= PH_RUN;
          cal_x <= loaded_x;
          cal_y <= loaded_y;
        end
      end else if (loaded_hit && !calibrate_first) begin
        cal_x <= loaded_x_next;
        cal_y <= loaded_y_next;
      end
    end else if (push) begin
      phase <= phase_next;
      cal_x <= cal_x_next;
      cal_y <= cal_y_next;
    end
  end

endmodule

FILE: sv/jcn_queue.sv
// Short job queue decoupling the front end from the divider back end.
module jcn_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jcn_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output jcn_pkg::job_t pop_job,
  output logic          empty
);
  import jcn_pkg::*;

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_job = slots[rd_ptr];

  // Storage writes
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

FILE: sv/jcn_back.sv
// Back end: two-lane restoring divider for normalization and result register.
module jcn_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_empty,
  output logic                            pop,
  input  jcn_pkg::job_t                   job,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [jcn_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import jcn_pkg::*;

  back_state_t              state, state_next;
  job_t                     cur;
  logic [STEP_W-1:0]        step;
  logic                     step_last;
  logic                     load_out;

  // Per-lane registers, lane 0 is x, lane 1 is y
  logic signed [DIFF_W-1:0] diff [2];
  logic signed [DIFF_W-1:0] dvs  [2];
  logic [ADC_BITS-1:0]      den  [2];
  logic [ADC_BITS-1:0]      rem  [2];
  logic [NUM_W-1:0]         quo  [2];
  logic                     neg  [2];
  logic                     fault[2];

  // Per-lane combinational values
  sample_t                  raw_l [2];
  axis_cal_t                cal_l [2];
  logic signed [DIFF_W-1:0] d_c   [2];
  logic signed [DIFF_W-1:0] up_c  [2];
  logic signed [DIFF_W-1:0] dn_c  [2];
  logic [ADC_BITS-1:0]      mag_c [2];
  logic [ADC_BITS-1:0]      den_c [2];
  logic [ADC_BITS:0]        rsh_c [2];
  logic                     fit_c [2];
  logic signed [NUM_W:0]    qs_c  [2];
  logic signed [EXT_W-1:0]  qe_c  [2];
  logic [OUT_W-1:0]         norm_c[2];
  logic                     run;

  assign run       = (cur.phase == PH_RUN);
  assign step_last = (step == STEP_W'(NUM_W - 1));

  // Lane arithmetic
  always_comb begin
    raw_l[0] = cur.raw_x;
    raw_l[1] = cur.raw_y;
    cal_l[0] = cur.cal_x;
    cal_l[1] = cur.cal_y;
    for (int l = 0; l < 2; l++) begin
      d_c[l]   = $signed({1'b0, raw_l[l]}) - $signed({1'b0, cal_l[l].ce});
      up_c[l]  = $signed({1'b0, cal_l[l].mx}) - $signed({1'b0, cal_l[l].ce});
      dn_c[l]  = $signed({1'b0, cal_l[l].ce}) - $signed({1'b0, cal_l[l].mn});
      mag_c[l] = diff[l][DIFF_W-1] ? ADC_BITS'(-diff[l]) : ADC_BITS'(diff[l]);
      den_c[l] = dvs[l][DIFF_W-1] ? ADC_BITS'(-dvs[l]) : ADC_BITS'(dvs[l]);
      rsh_c[l] = {rem[l], quo[l][NUM_W-1]};
      fit_c[l] = (rsh_c[l] >= {1'b0, den[l]});
      // apply sign, then saturate to the output range
      qs_c[l]  = neg[l] ? -$signed({1'b0, quo[l]}) : $signed({1'b0, quo[l]});
      qe_c[l]  = EXT_W'(qs_c[l]);
      if (!run || fault[l]) norm_c[l] = '0;
      else if (qe_c[l] > OUT_MAX_E) norm_c[l] = OUT_W'(OUT_MAX_E);
      else if (qe_c[l] < OUT_MIN_E) norm_c[l] = OUT_W'(OUT_MIN_E);
      else norm_c[l] = OUT_W'(qe_c[l]);
    end
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  // Sequencer next state and controls
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          state_next = (job.phase == PH_RUN) ? B_DIFF : B_DONE;
        end
      end
      B_DIFF:  state_next = B_SCALE;
      B_SCALE: state_next = B_DIV;
      B_DIV:   if (step_last) state_next = B_DONE;
      B_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (pop) begin
          cur <= job;
          for (int l = 0; l < 2; l++) fault[l] <= 1'b0;
        end
      end
      B_DIFF: begin
        for (int l = 0; l < 2; l++) begin
          diff[l] <= d_c[l];
          dvs[l]  <= (d_c[l] > 0) ? up_c[l] : dn_c[l];
        end
      end
      B_SCALE: begin
        step <= '0;
        for (int l = 0; l < 2; l++) begin
          quo[l]   <= NUM_W'(mag_c[l] * SCALE_K);
          den[l]   <= den_c[l];
          rem[l]   <= '0;
          neg[l]   <= diff[l][DIFF_W-1] ^ dvs[l][DIFF_W-1];
          fault[l] <= (dvs[l] == '0);
        end
      end
      B_DIV: begin
        step <= step + 1'b1;
        for (int l = 0; l < 2; l++) begin
          if (fit_c[l]) rem[l] <= ADC_BITS'(rsh_c[l] - {1'b0, den[l]});
          else rem[l] <= ADC_BITS'(rsh_c[l]);
          quo[l] <= {quo[l][NUM_W-2:0], fit_c[l]};
        end
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {{OUT_PAD_W{1'b0}}, fault[1] && run, fault[0] && run, run,
                  cur.phase, cur.pressed_b, cur.pressed_a, norm_c[1], norm_c[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (load_out) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

endmodule

FILE: sv/joystick_calibrate_normalize_unit.sv
// Top level of the joystick calibrate/normalize block.
//
//  Channel  Dir  Signals                       Carries
//  sample   in   s_tvalid s_tready s_tdata     raw_x, raw_y, level_a, level_b
//  result   out  m_tvalid m_tready m_tdata     norm_x, norm_y, buttons, phase, flags
//  config   in   cfg_we cfg_index cfg_data     calibrate_first, loaded min/center/max
//
// A sample handled in run phase passes the diff and scale states, then the
// shift-subtract divider that works both axes side by side, one quotient bit
// per cycle. Calibration-phase samples skip those states and the divider.
// With queue room, the front end classifies one sample per cycle into a
// two-entry job queue, so input and output stall independently. Reset is
// synchronous; it clears phase to seed and calibration/loaded to 0/512/1024.
module joystick_calibrate_normalize_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // raw_x, raw_y, level_a, level_b, zero fill
  input  logic [jcn_pkg::IN_W-1:0]        s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // norm_x, norm_y, pressed_a, pressed_b, phase_now, norm_valid, fault_x, fault_y, zero fill
  output logic [jcn_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                            cfg_we,
  input  logic [jcn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [jcn_pkg::CFG_W-1:0]       cfg_data
);
  import jcn_pkg::*;

  logic push, pop, q_full, q_empty;
  job_t push_job, pop_job;

  jcn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_job  (push_job),
    .q_full    (q_full)
  );

  jcn_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  jcn_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .pop      (pop),
    .job      (pop_job),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

FILE: test/joystick_result_checker.sv
// Result checker for the joystick calibrate/normalize unit: predicts each reading and compares.
module joystick_result_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [jcn_pkg::IN_W-1:0]        s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [jcn_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                            cfg_we,
  input  logic [jcn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [jcn_pkg::CFG_W-1:0]       cfg_data,
  output int                              fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import jcn_pkg::*;

  // Result field positions in m_tdata
  localparam int NY_LSB    = OUT_W;
  localparam int PA_BIT    = 2 * OUT_W;
  localparam int PB_BIT    = PA_BIT + 1;
  localparam int PH_LSB    = PA_BIT + 2;
  localparam int VALID_BIT = PH_LSB + 3;
  localparam int FX_BIT    = VALID_BIT + 1;
  localparam int FY_BIT    = VALID_BIT + 2;

  typedef struct packed {
    logic signed [OUT_W-1:0] norm_x;
    logic signed [OUT_W-1:0] norm_y;
    logic                    pressed_a;
    logic                    pressed_b;
    phase_t                  phase_now;
    logic                    norm_valid;
    logic                    fault_x;
    logic                    fault_y;
  } reading_t;

  // Shadow of the block: register file and live calibration
  logic      cal_first;
  axis_cal_t preset_x, preset_y;
  axis_cal_t live_x, live_y;
  phase_t    cal_phase;

  reading_t queued_readings[$];
  reading_t want, got;
  int       mismatches = 0;
  int       outstanding = 0;

  always_comb fail_count = mismatches + outstanding;

  // Follow phase ends as far as one sample's buttons allow
  function automatic phase_t next_phase(phase_t p, logic a, logic b);
    phase_t q;
    q = p;
    forever begin
      if ((q == PH_WAIT1 || q == PH_WAIT2 || q == PH_WAIT3) && a)
        q = phase_t'(q + 1);
      else if ((q == PH_TRACK || q == PH_CENTER) && b)
        q = phase_t'(q + 1);
      else
        return q;
    end
  endfunction

  // (raw - center) * 1000 over the half-range on raw's side, truncated toward zero
  function automatic logic signed [OUT_W-1:0] scale_axis(sample_t raw, axis_cal_t c,
                                                          output logic fault);
    int r, mn, ce, mx, d, span, q;
    r = raw;
    mn = c.mn;
    ce = c.ce;
    mx = c.mx;
    d = r - ce;
    span = (d > 0) ? mx - ce : ce - mn;
    if (span == 0) begin
      fault = 1'b1;
      return '0;
    end
    fault = 1'b0;
    q = (d * SCALE) / span;
    if (q > 4194303) q = 4194303;
    if (q < -4194304) q = -4194304;
    return OUT_W'(q);
  endfunction

  // One sample through the calibration sequence; updates the shadow state
  function automatic reading_t calibrate_and_scale(sample_t rx, sample_t ry,
                                                   logic lvl_a, logic lvl_b);
    reading_t r;
    logic fx, fy;
    r = '0;
    r.pressed_a = !lvl_a;
    r.pressed_b = !lvl_b;
    r.phase_now = cal_phase;
    if (cal_phase == PH_RUN) begin
      r.norm_x = scale_axis(rx, live_x, fx);
      r.norm_y = scale_axis(ry, live_y, fy);
      r.fault_x = fx;
      r.fault_y = fy;
      r.norm_valid = 1'b1;
    end else begin
      case (cal_phase)
        PH_SEED: begin
          live_x.mn = rx;
          live_x.mx = rx;
          live_y.mn = ry;
          live_y.mx = ry;
        end
        PH_TRACK: begin
          if (rx > live_x.mx) live_x.mx = rx;
          if (rx < live_x.mn) live_x.mn = rx;
          if (ry > live_y.mx) live_y.mx = ry;
          if (ry < live_y.mn) live_y.mn = ry;
        end
        PH_CENTER: begin
          live_x.ce = rx;
          live_y.ce = ry;
        end
        default: ;
      endcase
      cal_phase = next_phase((cal_phase == PH_SEED) ? PH_WAIT1 : cal_phase,
                             r.pressed_a, r.pressed_b);
    end
    return r;
  endfunction

  // Register write: restart on calibrate_first, copy-through when not calibrating
  function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, sample_t val);
    case (idx)
      REG_CAL_FIRST: begin
        cal_first = val[0];
        cal_phase = cal_first ? PH_SEED : PH_RUN;
      end
      REG_MIN_X:    preset_x.mn = val;
      REG_CENTER_X: preset_x.ce = val;
      REG_MAX_X:    preset_x.mx = val;
      REG_MIN_Y:    preset_y.mn = val;
      REG_CENTER_Y: preset_y.ce = val;
      REG_MAX_Y:    preset_y.mx = val;
      default: ;
    endcase
    if (!cal_first) begin
      live_x = preset_x;
      live_y = preset_y;
    end
  endfunction

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Watch config, request and result channels
  always @(posedge clk) begin
    if (rst) begin
      cal_first = 1'b1;
      preset_x = CAL_RESET;
      preset_y = CAL_RESET;
      live_x = CAL_RESET;
      live_y = CAL_RESET;
      cal_phase = PH_SEED;
      queued_readings.delete();
    end else begin
      if (cfg_we) apply_write(cfg_index, cfg_data);
      if (s_tvalid && s_tready)
        queued_readings.push_back(calibrate_and_scale(
          s_tdata[ADC_BITS-1:0], s_tdata[2*ADC_BITS-1:ADC_BITS],
          s_tdata[2*ADC_BITS], s_tdata[2*ADC_BITS+1]));
      if (m_tvalid && m_tready) begin
        got.norm_x     = m_tdata[OUT_W-1:0];
        got.norm_y     = m_tdata[NY_LSB+OUT_W-1:NY_LSB];
        got.pressed_a  = m_tdata[PA_BIT];
        got.pressed_b  = m_tdata[PB_BIT];
        got.phase_now  = phase_t'(m_tdata[PH_LSB+2:PH_LSB]);
        got.norm_valid = m_tdata[VALID_BIT];
        got.fault_x    = m_tdata[FX_BIT];
        got.fault_y    = m_tdata[FY_BIT];
        if (queued_readings.size() == 0) begin
          $error("result with no reading expected: m_tdata 0x%0h", m_tdata);
          mismatches++;
        end else begin
          want = queued_readings.pop_front();
          check_field("norm_x", want.norm_x, got.norm_x);
          check_field("norm_y", want.norm_y, got.norm_y);
          check_field("pressed_a", want.pressed_a, got.pressed_a);
          check_field("pressed_b", want.pressed_b, got.pressed_b);
          check_field("phase_now", want.phase_now, got.phase_now);
          check_field("norm_valid", want.norm_valid, got.norm_valid);
          check_field("fault_x", want.fault_x, got.fault_x);
          check_field("fault_y", want.fault_y, got.fault_y);
        end
      end
    end
    outstanding = queued_readings.size();
  end

endmodule

FILE: test/tb.sv
// Testbench top for the joystick calibrate/normalize unit: stimulus, idling and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import jcn_pkg::*;

  localparam int TOTAL_ITEMS = 950;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = '1;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_W-1:0]        s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;
  int                     fail_count;

  // Idle plans per episode: none, sender, receiver, both lightly
  int gap_plan[4]   = '{0, 77, 0, 6};
  int stall_plan[4] = '{0, 0, 77, 6};
  int gap_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;

  int samples_sent = 0;
  int results_taken = 0;

  joystick_calibrate_normalize_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  joystick_result_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Count accepted results
  always @(posedge clk) begin
    if (m_tvalid && m_tready) results_taken <= results_taken + 1;
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Mostly random sample with extra weight on the rails
  function automatic sample_t pick_sample();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return sample_t'($urandom_range(2 ** ADC_BITS - 1));
  endfunction

  // Pin level: 0 (pressed) with the given chance
  function automatic logic level_for(int press_pct);
    return ($urandom_range(99) >= press_pct);
  endfunction

  function automatic axis_cal_t pick_preset();
    axis_cal_t c;
    c.mn = pick_sample();
    c.ce = pick_sample();
    c.mx = pick_sample();
    // flat axis now and then: zero span on both sides
    if ($urandom_range(4) == 0) begin
      c.ce = c.mn;
      c.mx = c.mn;
    end
    return c;
  endfunction

  // One request; called right after a rising edge
  task automatic offer_sample(sample_t rx, sample_t ry, logic lvl_a, logic lvl_b);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata <= IN_W'({lvl_b, lvl_a, ry, rx});
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    samples_sent++;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    s_tvalid <= 1'b0;
    while (results_taken != samples_sent) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_axes(axis_cal_t cx, axis_cal_t cy);
    write_reg(REG_MIN_X, cx.mn);
    write_reg(REG_CENTER_X, cx.ce);
    write_reg(REG_MAX_X, cx.mx);
    write_reg(REG_MIN_Y, cy.mn);
    write_reg(REG_CENTER_Y, cy.ce);
    write_reg(REG_MAX_Y, cy.mx);
  endtask

  // Stimulus
  initial begin
    int episode;
    int roll;
    axis_cal_t px, py;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: full button-driven calibration from reset
    offer_sample(2000, 2000, 1, 1);   // seed
    offer_sample(0, 0, 1, 1);         // waiting, A released
    offer_sample(10, 10, 0, 1);       // A starts tracking
    offer_sample(0, 4095, 1, 1);
    offer_sample(4095, 0, 1, 1);
    offer_sample(1000, 3000, 0, 0);   // B ends tracking; A and B chain on through center to run
    offer_sample(2048, 2048, 1, 1);   // already in run: no center capture
    offer_sample(2047, 2049, 1, 0);   // B pressed in run
    offer_sample(3000, 1000, 1, 1);   // run
    offer_sample(5, 5, 0, 1);         // A pressed in run
    offer_sample(0, 0, 1, 1);
    offer_sample(4095, 4095, 1, 1);
    offer_sample(2047, 2049, 1, 1);   // near mid-scale
    offer_sample(2100, 1000, 0, 0);
    drain();

    // Loaded values: flat x axis, inverted y axis
    load_axes('{mn: 7, ce: 7, mx: 7}, '{mn: 3000, ce: 2000, mx: 100});
    write_reg(REG_CAL_FIRST, 0);
    offer_sample(7, 4095, 1, 1);
    offer_sample(4095, 0, 1, 1);
    offer_sample(0, 2000, 1, 1);
    drain();

    // Loaded write while running goes live at once
    write_reg(REG_MAX_X, 4095);
    offer_sample(4095, 1, 1, 1);
    offer_sample(0, 3000, 0, 1);
    drain();

    // Restart; a seed showing both buttons chains straight to run
    write_reg(REG_CAL_FIRST, 1);
    offer_sample(1234, 3210, 0, 0);
    offer_sample(0, 4095, 1, 1);
    drain();

    // Unknown register index is ignored
    write_reg(REG_UNUSED, '1);
    offer_sample(4095, 0, 1, 1);
    drain();

    // Random episodes
    episode = 0;
    while (samples_sent < TOTAL_ITEMS) begin
      drain();
      gap_pct = gap_plan[episode % 4];
      stall_pct = stall_plan[episode % 4];
      roll = $urandom_range(99);
      if (roll < 70) begin
        // well-formed calibration sequence with random content
        write_reg(REG_CAL_FIRST, 1);
        offer_sample(pick_sample(), pick_sample(), level_for(5), level_for(5));
        repeat ($urandom_range(2)) offer_sample(pick_sample(), pick_sample(), 1, 1);
        offer_sample(pick_sample(), pick_sample(), 0, level_for(10));
        repeat ($urandom_range(8, 1))
          offer_sample(pick_sample(), pick_sample(), level_for(30), 1);
        offer_sample(pick_sample(), pick_sample(), level_for(30), 0);
        repeat ($urandom_range(2)) offer_sample(pick_sample(), pick_sample(), 1, 1);
        offer_sample(pick_sample(), pick_sample(), 0, 1);
        repeat ($urandom_range(4, 1))
          offer_sample(pick_sample(), pick_sample(), level_for(30), 1);
        offer_sample(pick_sample(), pick_sample(), level_for(30), 0);
        repeat ($urandom_range(2)) offer_sample(pick_sample(), pick_sample(), 1, 1);
        offer_sample(pick_sample(), pick_sample(), 0, level_for(30));
      end else if (roll < 90) begin
        // loaded values, sometimes written after calibrate_first drops
        px = pick_preset();
        py = pick_preset();
        if ($urandom_range(3) == 0) begin
          write_reg(REG_CAL_FIRST, 0);
          load_axes(px, py);
        end else begin
          load_axes(px, py);
          write_reg(REG_CAL_FIRST, 0);
        end
      end else begin
        // noise: random buttons from seed on
        write_reg(REG_CAL_FIRST, 1);
        repeat ($urandom_range(40, 10))
          offer_sample(pick_sample(), pick_sample(), level_for(50), level_for(50));
      end

      // long receiver hold-off while the sender keeps going
      if (episode == 4) begin
        hold_req = 1'b1;
        gap_pct = 0;
      end
      repeat ($urandom_range(40, 5))
        offer_sample(pick_sample(), pick_sample(), level_for(30), level_for(30));
      episode++;
    end

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: sim.f
sv/jcn_pkg.sv
sv/jcn_front.sv
sv/jcn_queue.sv
sv/jcn_back.sv
sv/joystick_calibrate_normalize_unit.sv
test/joystick_result_checker.sv
test/tb.sv
